>>> rtl/core/kcf_pkg.sv
// Shared types, constants and the log2 table of the k-mer composition block.
package kcf_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned NUM_BASES     = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // window length limit; fits LEN_W
  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // log2 in Q.32 for 0..2^LEN_W-1: integer part below 6 needs 3 bits, kept at 5
  localparam int unsigned LOG_FRAC  = 32;
  localparam int unsigned LOG_W     = LOG_FRAC + 5;
  localparam int unsigned PROD_W    = LOG_W + LEN_W;
  localparam int unsigned TAB_DEPTH = 2 ** LEN_W;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef logic [LEN_W-1:0] count_t;

  // per-window summary handed from front to back
  typedef struct packed {
    count_t [NUM_BASES-1:0] counts;
    count_t                 length;
    count_t                 best_run;
    logic                   invalid;
    logic                   overflow;
  } win_sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DGC,
    ST_GCL,
    ST_DENT,
    ST_HOLD
  } back_state_t;

  typedef logic [TAB_DEPTH-1:0][LOG_W-1:0] log_tab_t;

  // bitwise log2 by repeated squaring of a Q2.30 mantissa
  function automatic logic [LOG_W-1:0] log2_q32(input int unsigned x);
    longint unsigned    y;
    logic [LOG_W-1:0]   res;
    int unsigned        k;
    res = '0;
    k   = 0;
    if (x != 0) begin
      while (k < 31 && (x >> (k + 1)) != 0) begin
        k++;
      end
      y   = (longint'(x) << 30) >> k;
      res = LOG_W'(k) << LOG_FRAC;
      for (int i = LOG_FRAC - 1; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          res[i] = 1'b1;
          y      = y >> 1;
        end
      end
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      tab[i] = log2_q32(i);
    end
    return tab;
  endfunction

  localparam log_tab_t LOG2_TAB = build_log_tab();

endpackage

>>> rtl/core/kcf_front.sv
// Front end: per-base counting, run tracking and window summary.
module kcf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [kcf_pkg::CHAR_W-1:0]  base_char,
  input  logic                        last_base,
  output logic                        win_push,
  output kcf_pkg::win_sum_t           win_sum
);
  import kcf_pkg::*;

  count_t [NUM_BASES-1:0] counts, counts_next;
  count_t                 length, length_next;
  logic [CHAR_W-1:0]      prev_char, prev_char_next;
  count_t                 cur_run, cur_run_next;
  count_t                 best_run, best_run_next;
  logic                   invalid, invalid_next;
  logic                   overflow, overflow_next;

  base_idx_t idx;
  logic      base_ok;

  always_comb begin
    unique case (base_char)
      CHAR_A: begin idx = BASE_A; base_ok = 1'b1; end
      CHAR_C: begin idx = BASE_C; base_ok = 1'b1; end
      CHAR_G: begin idx = BASE_G; base_ok = 1'b1; end
      CHAR_T: begin idx = BASE_T; base_ok = 1'b1; end
      default: begin idx = BASE_A; base_ok = 1'b0; end
    endcase
  end

  always_comb begin
    counts_next    = counts;
    length_next    = length;
    prev_char_next = prev_char;
    cur_run_next   = cur_run;
    best_run_next  = best_run;
    invalid_next   = invalid;
    overflow_next  = overflow;
    if (accept) begin
      if (length >= MAX_LEN) begin
        overflow_next = 1'b1;  // dropped base
      end else begin
        if (base_ok) begin
          counts_next[idx] = counts[idx] + count_t'(1);
        end else begin
          invalid_next = 1'b1;
        end
        if (length == '0 || base_char != prev_char) begin
          cur_run_next = count_t'(1);
        end else begin
          cur_run_next = cur_run + count_t'(1);
        end
        if (cur_run_next > best_run) begin
          best_run_next = cur_run_next;
        end
        prev_char_next = base_char;
        length_next    = length + count_t'(1);
      end
    end
  end

  assign win_push          = accept && last_base;
  assign win_sum.counts    = counts_next;
  assign win_sum.length    = length_next;
  assign win_sum.best_run  = best_run_next;
  assign win_sum.invalid   = invalid_next;
  assign win_sum.overflow  = overflow_next;

  always_ff @(posedge clk) begin
    if (rst || win_push) begin
      counts    <= '0;
      length    <= '0;
      prev_char <= '0;
      cur_run   <= '0;
      best_run  <= '0;
      invalid   <= 1'b0;
      overflow  <= 1'b0;
    end else begin
      counts    <= counts_next;
      length    <= length_next;
      prev_char <= prev_char_next;
      cur_run   <= cur_run_next;
      best_run  <= best_run_next;
      invalid   <= invalid_next;
      overflow  <= overflow_next;
    end
  end

endmodule

>>> rtl/core/kcf_queue.sv
// Short queue of window summaries between front and back.
module kcf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kcf_pkg::win_sum_t  push_data,
  input  logic               pop,
  output kcf_pkg::win_sum_t  pop_data,
  output logic               full,
  output logic               empty
);
  import kcf_pkg::*;

  win_sum_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  logic do_push;
  logic do_pop;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/kcf_back.sv
// Back end: entropy sum, shared serial divider and result register.
module kcf_back #(
  parameter int unsigned FRAC_BITS = kcf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  kcf_pkg::win_sum_t           q_data,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [FRAC_BITS:0]          gc_frac_q16,
  output logic [FRAC_BITS+1:0]        entropy_q16,
  output logic [kcf_pkg::LEN_W-1:0]   longest_run,
  output logic [2:0]                  bases_present,
  output logic [kcf_pkg::LEN_W-1:0]   window_length,
  output logic [1:0]                  status
);
  import kcf_pkg::*;

  localparam int unsigned SHIFT  = LOG_FRAC - FRAC_BITS;
  localparam int unsigned DVD_W  = PROD_W - SHIFT;
  localparam int unsigned CNT_W  = $clog2(DVD_W);
  localparam int unsigned REM_W  = LEN_W + 1;
  localparam int unsigned GC_W   = FRAC_BITS + 1;
  localparam int unsigned ENT_W  = FRAC_BITS + 2;
  localparam int unsigned STEP_W = $clog2(NUM_BASES + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_BASES);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DVD_W - 1);
  localparam logic [ENT_W-1:0]  ENT_MAX   = ENT_W'(2) << FRAC_BITS;

  back_state_t state, state_next;

  // control decoded from state
  logic win_load, mul_en, div_load_gc, div_step, div_load_ent, res_load;

  win_sum_t            win;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   prod;
  logic                prod_vld;
  logic                prod_first;
  logic [PROD_W-1:0]   tot;
  logic [PROD_W-1:0]   acc_sum;
  logic [PROD_W-1:0]   t_diff;
  logic [DVD_W-1:0]    dvd;
  logic [REM_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt;
  logic [GC_W-1:0]     gc_q;
  logic                out_valid;

  count_t              mul_a;
  logic [LOG_W-1:0]    mul_log;
  logic [LEN_W:0]      gc_sum;
  logic [DVD_W-1:0]    gc_num;
  logic [PROD_W:0]     ent_sum;
  logic [REM_W-1:0]    rem_sh;
  logic                quo_bit;
  logic [ENT_W-1:0]    ent_sat;
  logic [2:0]          distinct;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_MUL;
      ST_MUL:  if (step == STEP_LAST) state_next = ST_ACC;
      ST_ACC:  state_next = ST_DGC;
      ST_DGC:  if (cnt == CNT_LAST) state_next = ST_GCL;
      ST_GCL:  state_next = ST_DENT;
      ST_DENT: if (cnt == CNT_LAST) state_next = ST_HOLD;
      ST_HOLD: if (!out_valid || pop) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    win_load     = 1'b0;
    mul_en       = 1'b0;
    div_load_gc  = 1'b0;
    div_step     = 1'b0;
    div_load_ent = 1'b0;
    res_load     = 1'b0;
    unique case (state)
      ST_IDLE: win_load     = !q_empty;
      ST_MUL:  mul_en       = 1'b1;
      ST_ACC:  div_load_gc  = 1'b1;
      ST_DGC:  div_step     = 1'b1;
      ST_GCL:  div_load_ent = 1'b1;
      ST_DENT: div_step     = 1'b1;
      ST_HOLD: res_load     = !out_valid || pop;
      default: ;
    endcase
  end

  assign q_pop = win_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one product a cycle: n*L(n) first, then c*L(c) for each base
  assign mul_a   = (step == '0) ? win.length : win.counts[2'(step - STEP_W'(1))];
  assign mul_log = LOG2_TAB[mul_a];

  always_ff @(posedge clk) begin
    if (win_load) begin
      win  <= q_data;
      step <= '0;
    end else if (mul_en) begin
      step <= step + STEP_W'(1);
    end
    if (mul_en) begin
      prod       <= PROD_W'(mul_a) * PROD_W'(mul_log);
      prod_first <= (step == '0);
    end
    if (win_load) begin
      acc_sum <= '0;
    end else if (prod_vld) begin
      if (prod_first) begin
        tot <= prod;
      end else begin
        acc_sum <= acc_sum + prod;
      end
    end
    t_diff <= (acc_sum > tot) ? '0 : tot - acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_en;
    end
  end

  // dividend set-up: GC with rounding, entropy pre-scaled so the divisor is n
  assign gc_sum  = {1'b0, win.counts[BASE_C]} + {1'b0, win.counts[BASE_G]};
  assign gc_num  = (DVD_W'(gc_sum) << FRAC_BITS) + DVD_W'(win.length >> 1);
  assign ent_sum = {1'b0, t_diff} + ((PROD_W + 1)'(win.length) << (SHIFT - 1));

  // restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign quo_bit = (rem_sh >= {1'b0, win.length});

  always_ff @(posedge clk) begin
    if (div_load_gc) begin
      dvd <= gc_num;
      rem <= '0;
      cnt <= '0;
    end else if (div_load_ent) begin
      gc_q <= dvd[GC_W-1:0];
      dvd  <= ent_sum[PROD_W-1:SHIFT];
      rem  <= '0;
      cnt  <= '0;
    end else if (div_step) begin
      dvd <= {dvd[DVD_W-2:0], quo_bit};
      rem <= quo_bit ? rem_sh - {1'b0, win.length} : rem_sh;
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign ent_sat = (dvd > DVD_W'(ENT_MAX)) ? ENT_MAX : dvd[ENT_W-1:0];

  always_comb begin
    distinct = '0;
    for (int i = 0; i < NUM_BASES; i++) begin
      distinct = distinct + 3'(win.counts[i] != '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      gc_frac_q16    <= gc_q;
      entropy_q16    <= win.invalid ? '0 : ent_sat;
      longest_run    <= win.best_run;
      bases_present  <= distinct;
      window_length  <= win.length;
      status         <= win.invalid  ? STATUS_INVALID :
                        win.overflow ? STATUS_OVERFLOW : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

>>> rtl/core/kmer_composition_features.sv
// Top level of the k-mer composition statistics block.
//
// Bases of a DNA window come in one ASCII character per transfer, the last
// one flagged by last_base. Each window yields one result: GC fraction
// (Q1.FRAC_BITS, rounded), Shannon entropy in bits (Q2.FRAC_BITS, zero if a
// non-ACGT character was seen), longest homopolymer run, number of distinct
// bases, window length and status (0 ok, 1 invalid character, 2 window
// longer than MAX_LEN; invalid wins). Bases past MAX_LEN are dropped but the
// last flag still closes the window. The front end counts one base per
// cycle with no stall of its own. Each closed window is queued (two deep)
// for the back end, which per window does five table multiplies for the
// n*log2(n) and c*log2(c) terms, then two passes of a one-bit-per-cycle
// serial divider by the window length, GC first, entropy second. Windows
// that come faster than the back end finishes them make full rise once the
// queue is taken. A finished result sits in an output register while the
// back end starts on the next window; the next result waits for a pop.
module kmer_composition_features #(
  parameter int unsigned FRAC_BITS = kcf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [kcf_pkg::CHAR_W-1:0]  base_char,
  input  logic                        last_base,
  output logic                        empty,
  input  logic                        pop,
  output logic [FRAC_BITS:0]          gc_frac_q16,
  output logic [FRAC_BITS+1:0]        entropy_q16,
  output logic [kcf_pkg::LEN_W-1:0]   longest_run,
  output logic [2:0]                  bases_present,
  output logic [kcf_pkg::LEN_W-1:0]   window_length,
  output logic [1:0]                  status
);
  import kcf_pkg::*;

  logic     accept;      // base transfer this cycle
  logic     win_push;    // window closed, summary into queue
  win_sum_t win_sum;
  win_sum_t q_data;
  logic     q_pop;
  logic     q_empty;

  assign accept = push && !full;

  kcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .base_char (base_char),
    .last_base (last_base),
    .win_push  (win_push),
    .win_sum   (win_sum)
  );

  // full also holds off non-last bases: simple and never loses a window
  kcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (win_push),
    .push_data (win_sum),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (full),
    .empty     (q_empty)
  );

  kcf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .gc_frac_q16    (gc_frac_q16),
    .entropy_q16    (entropy_q16),
    .longest_run    (longest_run),
    .bases_present  (bases_present),
    .window_length  (window_length),
    .status         (status)
  );

`ifndef SYNTH
  // invalid windows carry no entropy
  a_invalid_zero_entropy: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STATUS_INVALID) |-> (entropy_q16 == '0))
    else $error("entropy nonzero on invalid window");

  // every window holds at least one counted base and no more than MAX_LEN
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (window_length != '0 && window_length <= MAX_LEN))
    else $error("window length out of range");

  // a run cannot outgrow its window
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (longest_run <= window_length && longest_run != '0))
    else $error("longest run inconsistent with length");

  // GC fraction never exceeds one
  a_gc_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (gc_frac_q16 <= {1'b1, {FRAC_BITS{1'b0}}}))
    else $error("GC fraction above one");
`endif

endmodule
